### rtl/core/vss_pkg.sv
// Package with shared types, constants and a helper function for the Verlet step block.
package vss_pkg;

    localparam int NUM_BODIES = 64;
    localparam int BODY_BITS  = 6;
    localparam int ADDR_BITS  = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;
    localparam int COORD_BITS = 32;
    localparam int PADDR_BITS = 5;

    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    localparam logic [PADDR_BITS-1:0] A_STEP_TIME   = 5'd0;
    localparam logic [PADDR_BITS-1:0] A_SPEED_LIMIT = 5'd4;
    localparam logic [PADDR_BITS-1:0] A_BOX_X_MIN   = 5'd8;
    localparam logic [PADDR_BITS-1:0] A_BOX_X_MAX   = 5'd12;
    localparam logic [PADDR_BITS-1:0] A_BOX_Y_MIN   = 5'd16;
    localparam logic [PADDR_BITS-1:0] A_BOX_Y_MAX   = 5'd20;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [5:0]        body;
        logic signed [31:0] load_pos_x;
        logic signed [31:0] load_pos_y;
        logic signed [31:0] load_prev_x;
        logic signed [31:0] load_prev_y;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
    } t_in_word;

    typedef struct packed {
        logic [5:0]         out_body;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_prev_x;
        logic signed [31:0] new_prev_y;
        logic               speed_clamped;
    } t_out_word;

    typedef struct packed {
        logic [15:0]        step_time;
        logic [30:0]        speed_limit;
        logic signed [31:0] box_x_min;
        logic signed [31:0] box_x_max;
        logic signed [31:0] box_y_min;
        logic signed [31:0] box_y_max;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_VERLET, S_DIFF, S_CHECK, S_NORM, S_SQRT,
        S_DIVX, S_DIVY, S_APPLY, S_WRAP, S_DONE
    } t_state;

    typedef struct packed {
        logic ld_in;
        logic do_verlet;
        logic do_diff;
        logic do_check;
        logic do_norm;
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
        logic div_sel_y;
        logic do_apply;
        logic do_wrap;
        logic do_write;
        logic do_load;
    } t_cmd;

    typedef struct packed {
        logic is_step;
        logic in_range;
        logic need_clamp;
        logic norm_done;
        logic iter_done;
    } t_stat;

    function automatic logic signed [COORD_BITS-1:0] sat_c(input logic signed [35:0] v);
        if (v > 36'sd2147483647)       return C_MAX;
        else if (v < -36'sd2147483648) return C_MIN;
        else                           return v[COORD_BITS-1:0];
    endfunction

endpackage

### rtl/core/vss_ram.sv
// Generic single-port RAM with registered read.
module vss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### rtl/core/vss_ctrl.sv
// Controller state machine that sequences the Verlet step datapath.
module vss_ctrl import vss_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.ld_in = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (!i_stat.in_range) begin
                    n_state = S_DONE;
                end else if (!i_stat.is_step) begin
                    o_cmd.do_load = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_VERLET;
                end
            end
            S_VERLET: begin
                o_cmd.do_verlet = 1'b1;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.do_diff = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.do_check = 1'b1;
                n_state = S_NORM;
            end
            S_NORM: begin
                if (!i_stat.need_clamp) begin
                    n_state = S_WRAP;
                end else if (i_stat.norm_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state = S_SQRT;
                end else begin
                    o_cmd.do_norm = 1'b1;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_stat.iter_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIVX;
                end
            end
            S_DIVX: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.iter_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel_y = 1'b1;
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_sel_y = 1'b1;
                if (i_stat.iter_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.do_apply = 1'b1;
                n_state = S_WRAP;
            end
            S_WRAP: begin
                o_cmd.do_wrap = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_done = 1'b1;
                o_cmd.do_write = i_stat.in_range;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |=> !o_busy)
        else $error("busy after done");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_cmd.ld_in |=> !o_done)
        else $error("done too early");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.do_write |-> o_done)
        else $error("write outside the done cycle");
endmodule

### rtl/core/vss_dp.sv
// Datapath with position stores, Verlet arithmetic, speed clamp and box wrap.
module vss_dp import vss_pkg::*; (
    input  logic      i_clk,
    input  t_in_word  i_in,
    input  t_cfg      i_cfg,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output t_out_word o_out
);
    t_in_word r_in;
    logic [ADDR_BITS-1:0] w_addr;
    logic signed [31:0] w_px, w_py, w_qx, w_qy;
    logic signed [31:0] r_px, r_py, r_qx, r_qy;
    logic signed [31:0] w_cur_x, w_cur_y, w_old_x, w_old_y;
    logic r_clamped;
    logic [31:0] r_d2;
    logic [31:0] r_lim;
    logic [47:0] w_lim_full;
    logic signed [63:0] w_tx, w_ty;
    logic signed [33:0] r_dx, r_dy;
    logic [32:0] r_ux, r_uy;
    logic [32:0] w_ax, w_ay;
    logic [66:0] w_mag, w_lim2;
    logic r_need;
    logic [63:0] r_rad, r_res, r_bit;
    logic [6:0] r_cnt;
    logic [63:0] w_trial;
    logic [31:0] r_n;
    logic [63:0] r_num, r_quo;
    logic [64:0] r_rem;
    logic [64:0] w_rsh;
    logic [31:0] r_cx;
    logic signed [35:0] w_sx, w_sy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) r_in <= i_in;
    end

    assign w_addr = r_in.body[ADDR_BITS-1:0];
    assign o_stat.is_step   = (r_in.req_type == REQ_STEP);
    assign o_stat.in_range  = ({26'd0, r_in.body} < NUM_BODIES);
    assign o_stat.need_clamp = r_need;
    assign o_stat.norm_done = (r_ux < 33'h40000000) && (r_uy < 33'h40000000);
    assign o_stat.iter_done = (r_cnt == 7'd0);

    always_comb begin
        w_px = r_px; w_py = r_py; w_qx = r_qx; w_qy = r_qy;
        if (i_cmd.do_load) begin
            w_px = r_in.load_pos_x; w_py = r_in.load_pos_y;
            w_qx = r_in.load_prev_x; w_qy = r_in.load_prev_y;
        end
    end

    vss_ram #(.WIDTH(32), .DEPTH(NUM_BODIES)) u_cur_x (.i_clk, .i_we(i_cmd.do_write),
        .i_addr(w_addr), .i_wdata(w_px), .o_rdata(w_cur_x));
    vss_ram #(.WIDTH(32), .DEPTH(NUM_BODIES)) u_cur_y (.i_clk, .i_we(i_cmd.do_write),
        .i_addr(w_addr), .i_wdata(w_py), .o_rdata(w_cur_y));
    vss_ram #(.WIDTH(32), .DEPTH(NUM_BODIES)) u_old_x (.i_clk, .i_we(i_cmd.do_write),
        .i_addr(w_addr), .i_wdata(w_qx), .o_rdata(w_old_x));
    vss_ram #(.WIDTH(32), .DEPTH(NUM_BODIES)) u_old_y (.i_clk, .i_we(i_cmd.do_write),
        .i_addr(w_addr), .i_wdata(w_qy), .o_rdata(w_old_y));

    assign w_lim_full = {16'd0, i_cfg.step_time} * {17'd0, i_cfg.speed_limit} + 48'd32768;
    assign w_tx = r_in.accel_x * $signed({1'b0, r_d2}) + 64'sh80000000;
    assign w_ty = r_in.accel_y * $signed({1'b0, r_d2}) + 64'sh80000000;
    assign w_ax = r_dx[33] ? 33'(-r_dx) : r_dx[32:0];
    assign w_ay = r_dy[33] ? 33'(-r_dy) : r_dy[32:0];
    assign w_mag  = 67'(r_ux) * 67'(r_ux) + 67'(r_uy) * 67'(r_uy);
    assign w_lim2 = 67'(r_lim) * 67'(r_lim);
    assign w_trial = r_res + r_bit;
    assign w_rsh = {r_rem[63:0], r_num[63]};
    assign w_sx = {{4{r_qx[31]}}, r_qx} + (r_dx[33] ? -$signed({4'd0, r_cx})
                                                    : $signed({4'd0, r_cx}));
    assign w_sy = {{4{r_qy[31]}}, r_qy} + (r_dy[33] ? -$signed({4'd0, r_quo[31:0]})
                                                    : $signed({4'd0, r_quo[31:0]}));

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_d2 <= {16'd0, i_cfg.step_time} * {16'd0, i_cfg.step_time};
            r_lim <= w_lim_full[47:16];
            r_clamped <= 1'b0;
            r_px <= '0; r_py <= '0; r_qx <= '0; r_qy <= '0;
        end
        if (i_cmd.do_load) begin
            r_px <= w_px; r_py <= w_py; r_qx <= w_qx; r_qy <= w_qy;
        end
        if (i_cmd.do_verlet) begin
            r_px <= sat_c({{3{w_cur_x[31]}}, w_cur_x, 1'b0} - {{4{w_old_x[31]}}, w_old_x}
                    + {{4{w_tx[63]}}, w_tx[63:32]});
            r_py <= sat_c({{3{w_cur_y[31]}}, w_cur_y, 1'b0} - {{4{w_old_y[31]}}, w_old_y}
                    + {{4{w_ty[63]}}, w_ty[63:32]});
            r_qx <= w_cur_x; r_qy <= w_cur_y;
        end
        if (i_cmd.do_diff) begin
            r_dx <= {{2{r_px[31]}}, r_px} - {{2{r_qx[31]}}, r_qx};
            r_dy <= {{2{r_py[31]}}, r_py} - {{2{r_qy[31]}}, r_qy};
        end
        if (i_cmd.do_check) begin
            r_ux <= w_ax;
            r_uy <= w_ay;
        end
        if (i_cmd.do_norm) begin
            r_ux <= r_ux >> 1; r_uy <= r_uy >> 1;
        end
        if (i_cmd.sqrt_start) begin
            r_rad <= 64'(w_mag);
            r_res <= '0;
            r_bit <= 64'h4000000000000000;
            r_cnt <= 7'd32;
            r_clamped <= 1'b1;
        end
        if (i_cmd.sqrt_step && r_cnt != 7'd0) begin
            if (r_rad >= w_trial) begin
                r_rad <= r_rad - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt - 7'd1;
        end
        if (i_cmd.div_start) begin
            if (r_cnt == 7'd0 && !i_cmd.div_sel_y) begin
                r_n <= (r_res[31:0] == 32'd0) ? 32'd1 : r_res[31:0];
                r_num <= 64'({31'd0, r_ux} * {32'd0, r_lim})
                       + 64'((r_res[31:0] == 32'd0) ? 32'd0 : {1'b0, r_res[31:1]});
            end else begin
                r_cx <= r_quo[31:0];
                r_num <= 64'({31'd0, r_uy} * {32'd0, r_lim}) + 64'({1'b0, r_n[31:1]});
            end
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= 7'd64;
        end else if (i_cmd.div_step && r_cnt != 7'd0) begin
            if (w_rsh >= {33'd0, r_n}) begin
                r_rem <= w_rsh - {33'd0, r_n};
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= w_rsh;
                r_quo <= {r_quo[62:0], 1'b0};
            end
            r_num <= {r_num[62:0], 1'b0};
            r_cnt <= r_cnt - 7'd1;
        end
        if (i_cmd.do_apply) begin
            r_px <= sat_c(w_sx);
            r_py <= sat_c(w_sy);
        end
        if (i_cmd.do_wrap) begin
            if (i_cfg.box_x_max > i_cfg.box_x_min) begin
                if (r_px > i_cfg.box_x_max) begin
                    r_px <= sat_c(36'(r_px) - (36'(i_cfg.box_x_max) - 36'(i_cfg.box_x_min)));
                    r_qx <= sat_c(36'(r_qx) - (36'(i_cfg.box_x_max) - 36'(i_cfg.box_x_min)));
                end else if (r_px < i_cfg.box_x_min) begin
                    r_px <= sat_c(36'(r_px) + (36'(i_cfg.box_x_max) - 36'(i_cfg.box_x_min)));
                    r_qx <= sat_c(36'(r_qx) + (36'(i_cfg.box_x_max) - 36'(i_cfg.box_x_min)));
                end
            end
            if (i_cfg.box_y_max > i_cfg.box_y_min) begin
                if (r_py > i_cfg.box_y_max) begin
                    r_py <= sat_c(36'(r_py) - (36'(i_cfg.box_y_max) - 36'(i_cfg.box_y_min)));
                    r_qy <= sat_c(36'(r_qy) - (36'(i_cfg.box_y_max) - 36'(i_cfg.box_y_min)));
                end else if (r_py < i_cfg.box_y_min) begin
                    r_py <= sat_c(36'(r_py) + (36'(i_cfg.box_y_max) - 36'(i_cfg.box_y_min)));
                    r_qy <= sat_c(36'(r_qy) + (36'(i_cfg.box_y_max) - 36'(i_cfg.box_y_min)));
                end
            end
        end
    end

    // The clamp decision is made on the exact squared length of the step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_norm) begin
            r_need <= 1'b1;
        end else if (i_cmd.do_check) begin
            r_need <= (67'(w_ax) * 67'(w_ax) + 67'(w_ay) * 67'(w_ay)) > w_lim2;
        end else if (i_cmd.sqrt_start) begin
            r_need <= 1'b0;
        end
    end

    assign o_out.out_body      = r_in.body;
    assign o_out.new_pos_x     = r_px;
    assign o_out.new_pos_y     = r_py;
    assign o_out.new_prev_x    = r_qx;
    assign o_out.new_prev_y    = r_qy;
    assign o_out.speed_clamped = r_clamped;

    assert property (@(posedge i_clk) i_cmd.do_apply |-> r_clamped)
        else $error("apply without clamp");
    assert property (@(posedge i_clk) i_cmd.do_write |-> o_stat.in_range)
        else $error("write out of range");
    assert property (@(posedge i_clk) i_cmd.sqrt_start |-> o_stat.norm_done)
        else $error("sqrt before normalization");
    assert property (@(posedge i_clk) i_cmd.sqrt_start |-> r_need)
        else $error("sqrt without clamp decision");
endmodule

### rtl/core/verlet_step_speed_limit_wrap.sv
// Top level of the Verlet step block with speed limit and periodic box.
// One word is worked on at a time and the next can be taken in the cycle after each result;
// the bit-serial root and the two 64-step divisions set the rate of clamped steps.
// Reset restores the register defaults; body positions are undefined until loaded.
module verlet_step_speed_limit_wrap import vss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_word              i_in,
    output logic                  o_valid,
    output t_out_word             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    t_cfg  r_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_time   <= 16'd1092;
            r_cfg.speed_limit <= 31'd655360;
            r_cfg.box_x_min   <= 32'sd0;
            r_cfg.box_x_max   <= 32'sd41943040;
            r_cfg.box_y_min   <= 32'sd0;
            r_cfg.box_y_max   <= 32'sd31457280;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                A_STEP_TIME:   r_cfg.step_time   <= pwdata[15:0];
                A_SPEED_LIMIT: r_cfg.speed_limit <= pwdata[30:0];
                A_BOX_X_MIN:   r_cfg.box_x_min   <= pwdata;
                A_BOX_X_MAX:   r_cfg.box_x_max   <= pwdata;
                A_BOX_Y_MIN:   r_cfg.box_y_min   <= pwdata;
                A_BOX_Y_MAX:   r_cfg.box_y_max   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            A_STEP_TIME:   prdata = {16'd0, r_cfg.step_time};
            A_SPEED_LIMIT: prdata = {1'b0, r_cfg.speed_limit};
            A_BOX_X_MIN:   prdata = r_cfg.box_x_min;
            A_BOX_X_MAX:   prdata = r_cfg.box_x_max;
            A_BOX_Y_MIN:   prdata = r_cfg.box_y_min;
            A_BOX_Y_MAX:   prdata = r_cfg.box_y_max;
            default:       prdata = '0;
        endcase
    end

    vss_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_stat(w_stat),
        .o_cmd(w_cmd), .o_busy(busy), .o_done(o_valid)
    );

    vss_dp u_dp (
        .i_clk, .i_in, .i_cfg(r_cfg), .i_cmd(w_cmd), .o_stat(w_stat), .o_out
    );
endmodule
